FILE: rtl/plasr_pkg.sv
package plasr_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_COMPARE,
		CELL_REMOVE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] value;
		logic [3:0]         pos;
	} cell_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_index;
		logic signed [31:0] removed_value;
		logic [4:0]         entry_count;
	} result_t;

endpackage

FILE: rtl/plasr_req_if.sv
interface plasr_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] value;
	logic [3:0]         position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);
endinterface

FILE: rtl/plasr_rsp_if.sv
interface plasr_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         found_index;
	logic signed [31:0] removed_value;
	logic [4:0]         entry_count;

	modport source (output valid, output status, output found_index, output removed_value,
		output entry_count, input ready);
	modport sink (input valid, input status, input found_index, input removed_value,
		input entry_count, output ready);
endinterface

FILE: rtl/plasr_cell.sv
module plasr_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plasr_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]       count,
	input  logic signed [31:0]  next_data,
	input  logic                next_match,
	output logic signed [31:0]  data,
	output logic                match
);

	logic signed [31:0] data_q;
	logic               match_q;
	logic               live;
	logic               at_end;
	logic               shift_in;

	assign live     = IDX < 32'(count);
	assign at_end   = IDX == 32'(count);
	assign shift_in = (IDX >= 32'(cmd.pos)) && (IDX + 32'd1 < 32'(count));

	always_ff @(posedge clk) begin
		case (cmd.op)
			plasr_pkg::CELL_APPEND: begin
				if (at_end) begin
					data_q <= cmd.value;
				end
			end
			plasr_pkg::CELL_REMOVE: begin
				if (shift_in) begin
					data_q <= next_data;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			case (cmd.op)
				plasr_pkg::CELL_COMPARE: match_q <= live && (data_q == cmd.value);
				plasr_pkg::CELL_SHIFT:   match_q <= next_match;
				default: ;
			endcase
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

FILE: rtl/packed_list_append_search_remove_top.sv
// Packed list of signed 32-bit values, DEPTH entries, held in a row of cells.
// Requests arrive on req (mode, value, position) and each request gives exactly
// one result item on rsp (status, found_index, removed_value, entry_count).
// Both channels move an item when valid and ready are high at a clock edge.
// Append, remove, a search on an empty list and an unknown mode pass from
// acceptance through the pending register to the output register: all cells
// update in parallel, and on remove every later cell takes the entry of its
// upper neighbor together. Search compares all live cells in parallel and
// then scans until the lowest match or the last entry: the match flags of
// the cells move one cell down per cycle toward cell zero while an index
// counter runs, which yields the lowest match.
// One request is in work at a time: a new request waits until the last one
// reaches the output register, so a search holds the input until it is done.
// req is ready while the block is idle, so a new request is taken while an
// earlier result still waits on rsp. If rsp stalls, the finished result waits
// in a pending register and the block holds the next request until the output
// register frees.
// Reset clears the entry count and the control state; entries are not
// cleared and need no clearing pass, since only entries below the count are
// read.
module packed_list_append_search_remove_top #(
	parameter int unsigned DEPTH = plasr_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	plasr_req_if.sink     req,
	plasr_rsp_if.source   rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > 4) ? CW : 4;

	plasr_pkg::state_t    state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        idx_q;
	plasr_pkg::result_t   pend_q, out_q;
	plasr_pkg::result_t   imm_res, scan_res;
	logic                 out_valid_q;
	plasr_pkg::cell_cmd_t cmd;

	logic signed [31:0]   cell_data  [DEPTH];
	logic                 cell_match [DEPTH];
	logic signed [31:0]   low_data   [16];

	logic accept;
	logic is_full;
	logic is_empty;
	logic rm_ok;
	logic search_go;
	logic scan_end;
	logic slot_free;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic signed [31:0] nd;
			logic               nm;
			if (g + 1 < DEPTH) begin : g_mid
				assign nd = cell_data[g + 1];
				assign nm = cell_match[g + 1];
			end else begin : g_top
				assign nd = '0;
				assign nm = 1'b0;
			end
			plasr_cell #(
				.IDX (g),
				.CW  (CW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.count      (count_q),
				.next_data  (nd),
				.next_match (nm),
				.data       (cell_data[g]),
				.match      (cell_match[g])
			);
		end
		for (g = 0; g < 16; g++) begin : g_low
			if (g < DEPTH) begin : g_on
				assign low_data[g] = cell_data[g];
			end else begin : g_off
				assign low_data[g] = '0;
			end
		end
	endgenerate

	assign req.ready = state_q == plasr_pkg::S_IDLE;
	assign accept    = req.valid && req.ready;
	assign is_full   = count_q == CW'(DEPTH);
	assign is_empty  = count_q == '0;
	assign rm_ok     = !is_empty && (XW'(req.position) < XW'(count_q));
	assign search_go = (req.mode == plasr_pkg::MODE_SEARCH) && !is_empty;
	assign scan_end  = cell_match[0] ||
		((CW + 1)'(idx_q) + (CW + 1)'(1) >= (CW + 1)'(count_q));
	assign slot_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plasr_pkg::S_IDLE: begin
				if (accept) begin
					state_d = search_go ? plasr_pkg::S_SCAN : plasr_pkg::S_DONE;
				end
			end
			plasr_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = plasr_pkg::S_DONE;
				end
			end
			plasr_pkg::S_DONE: begin
				if (slot_free) begin
					state_d = plasr_pkg::S_IDLE;
				end
			end
			default: state_d = plasr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = plasr_pkg::CELL_HOLD;
		cmd.value = req.value;
		cmd.pos   = req.position;
		count_d   = count_q;
		imm_res.status        = plasr_pkg::ST_OK;
		imm_res.found_index   = '0;
		imm_res.removed_value = '0;
		unique case (req.mode)
			plasr_pkg::MODE_APPEND: begin
				if (is_full) begin
					imm_res.status = plasr_pkg::ST_FULL;
				end else begin
					cmd.op  = plasr_pkg::CELL_APPEND;
					count_d = count_q + CW'(1);
				end
			end
			plasr_pkg::MODE_SEARCH: begin
				imm_res.status = plasr_pkg::ST_NOTFOUND;
				cmd.op         = plasr_pkg::CELL_COMPARE;
			end
			plasr_pkg::MODE_REMOVE: begin
				if (rm_ok) begin
					cmd.op                = plasr_pkg::CELL_REMOVE;
					imm_res.removed_value = low_data[req.position];
					count_d               = count_q - CW'(1);
				end else begin
					imm_res.status = plasr_pkg::ST_BAD;
				end
			end
			default: imm_res.status = plasr_pkg::ST_BAD;
		endcase
		imm_res.entry_count = 5'(count_d);
		if (!accept) begin
			cmd.op  = plasr_pkg::CELL_HOLD;
			count_d = count_q;
		end
		if (state_q == plasr_pkg::S_SCAN && !scan_end) begin
			cmd.op = plasr_pkg::CELL_SHIFT;
		end
		scan_res.status        = cell_match[0] ? plasr_pkg::ST_OK : plasr_pkg::ST_NOTFOUND;
		scan_res.found_index   = cell_match[0] ? 4'(idx_q) : 4'd0;
		scan_res.removed_value = '0;
		scan_res.entry_count   = 5'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plasr_pkg::S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == plasr_pkg::S_IDLE) begin
				idx_q <= '0;
			end else if (state_q == plasr_pkg::S_SCAN) begin
				idx_q <= idx_q + CW'(1);
			end
			if (state_q == plasr_pkg::S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plasr_pkg::S_IDLE && accept && !search_go) begin
			pend_q <= imm_res;
		end else if (state_q == plasr_pkg::S_SCAN && scan_end) begin
			pend_q <= scan_res;
		end
		if (state_q == plasr_pkg::S_DONE && slot_free) begin
			out_q <= pend_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.found_index   = out_q.found_index;
	assign rsp.removed_value = out_q.removed_value;
	assign rsp.entry_count   = out_q.entry_count;

endmodule
